### sv/mrm_pkg.sv
package mrm_pkg;

  // Matrix dimension and the widths that follow from it.
  localparam int DIM    = 16;
  localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ADDR_W = $clog2(DIM * DIM);

  // Fixed field widths of the stream payload.
  localparam int FIELD_IDX_W = 4;
  localparam int MODE_W      = 2;
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int SUM_W       = 48;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [MODE_W-1:0] {
    MODE_LEFT  = 2'd0,
    MODE_RIGHT = 2'd1,
    MODE_ROW   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_PUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              wr_left;
    logic              wr_right;
    logic [ADDR_W-1:0] wr_addr;
    logic              issue;
    logic              first;
    logic              last;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  k;
    logic              load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sum_ready;
    logic out_free;
  } dp_status_t;

  function automatic logic [ADDR_W-1:0] mat_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(DIM) + ADDR_W'(c);
  endfunction

endpackage

### sv/mrm_ctrl.sv
module mrm_ctrl
  import mrm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [MODE_W-1:0]      in_mode,
  input  logic [FIELD_IDX_W-1:0] in_row,
  input  logic [FIELD_IDX_W-1:0] in_col,
  output dp_cmd_t                cmd,
  input  dp_status_t             status
);

  state_t           state, state_next;
  logic [IDX_W-1:0] row, row_next;
  logic [IDX_W-1:0] col, col_next;
  logic [IDX_W-1:0] k, k_next;

  logic in_range_row;
  logic in_range_col;

  assign in_range_row = int'(in_row) < DIM;
  assign in_range_col = int'(in_col) < DIM;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row   <= '0;
      col   <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next   = state;
    row_next     = row;
    col_next     = col;
    k_next       = k;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.row      = row;
    cmd.col      = col;
    cmd.k        = k;
    cmd.wr_addr  = mat_addr(IDX_W'(in_row), IDX_W'(in_col));
    unique case (state)
      ST_IDLE: begin
        // Nothing is taken while reset is held.
        in_ready = !rst;
        if (in_valid && !rst) begin
          unique case (in_mode)
            MODE_LEFT:  cmd.wr_left  = in_range_row && in_range_col;
            MODE_RIGHT: cmd.wr_right = in_range_row && in_range_col;
            MODE_ROW: begin
              if (in_range_row) begin
                row_next   = IDX_W'(in_row);
                col_next   = '0;
                k_next     = '0;
                state_next = ST_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        cmd.first = (k == '0);
        cmd.last  = (k == IDX_W'(DIM - 1));
        k_next    = k + 1'b1;
        if (cmd.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.sum_ready) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          k_next       = '0;
          if (col == IDX_W'(DIM - 1)) begin
            state_next = ST_IDLE;
          end else begin
            col_next   = col + 1'b1;
            state_next = ST_ISSUE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### sv/mrm_datapath.sv
module mrm_datapath
  import mrm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  logic signed [ELEM_W-1:0] wr_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [FIELD_IDX_W-1:0]   out_row,
  output logic [FIELD_IDX_W-1:0]   out_col,
  output logic signed [SUM_W-1:0]  out_sum,
  output logic                     out_last
);

  logic signed [ELEM_W-1:0] left_mem  [DIM*DIM];
  logic signed [ELEM_W-1:0] right_mem [DIM*DIM];

  // Stage 1: registered memory reads.
  logic signed [ELEM_W-1:0] left_q, right_q;
  logic                     v1, first1, last1;
  // Stage 2: registered product.
  logic signed [PROD_W-1:0] prod;
  logic                     v2, first2, last2;
  // Stage 3: accumulation.
  logic signed [SUM_W-1:0]  acc;
  logic                     sum_ready;

  always_ff @(posedge clk) begin
    if (cmd.wr_left) begin
      left_mem[cmd.wr_addr] <= wr_value;
    end
    left_q <= left_mem[mat_addr(cmd.row, cmd.k)];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_right) begin
      right_mem[cmd.wr_addr] <= wr_value;
    end
    right_q <= right_mem[mat_addr(cmd.k, cmd.col)];
  end

  always_ff @(posedge clk) begin
    prod   <= left_q * right_q;
    first1 <= cmd.first;
    last1  <= cmd.last;
    first2 <= first1;
    last2  <= last1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      acc       <= '0;
      sum_ready <= 1'b0;
    end else begin
      v1        <= cmd.issue;
      v2        <= v1;
      sum_ready <= v2 && last2;
      if (v2) begin
        acc <= first2 ? SUM_W'(prod) : acc + SUM_W'(prod);
      end
    end
  end

  // Output register; it frees itself in the same cycle it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_row  <= FIELD_IDX_W'(cmd.row);
      out_col  <= FIELD_IDX_W'(cmd.col);
      out_sum  <= acc;
      out_last <= (cmd.col == IDX_W'(DIM - 1));
    end
  end

  assign status.sum_ready = sum_ready;
  assign status.out_free  = !out_valid || out_ready;

endmodule

### sv/matrix_row_multiply.sv
// Channel  | Signals                      | Payload (lowest bit first)
// ---------+------------------------------+---------------------------------------------
// input    | s_axis_tvalid/tready/tdata/  | tuser: mode; tdata: row_index, col_index,
//          | tuser                        | element_value (24 bits, no fill)
// output   | m_axis_tvalid/tready/tdata/  | tdata: out_row, out_col, product_sum,
//          | tlast                        | 56 bits, no fill; tlast: last_of_row
//
// A load transfer writes one matrix element. A compute transfer occupies the block
// until every column of the row is done, and it runs on the single shared
// multiply-accumulate unit: DIM reads per column, then a drain of the read,
// multiply and accumulate stages and a hand-off of the sum to the output
// register. A stalled output holds the engine in its hand-off state. Reset is
// synchronous; matrix contents are not cleared, and no input transfer is taken
// while reset is held.
module matrix_row_multiply
  import mrm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // row_index[3:0], col_index[7:4], element_value[23:8]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode[1:0]
  input  logic [MODE_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_row[3:0], out_col[7:4], product_sum[55:8]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [FIELD_IDX_W-1:0]   in_row, in_col;
  logic signed [ELEM_W-1:0] in_value;
  logic [FIELD_IDX_W-1:0]   out_row, out_col;
  logic signed [SUM_W-1:0]  out_sum;

  // Unpack the input transfer.
  assign in_row   = s_axis_tdata[3:0];
  assign in_col   = s_axis_tdata[7:4];
  assign in_value = s_axis_tdata[23:8];

  // The controller accepts transfers only while idle and sequences the
  // column and inner-product counters of a compute request.
  mrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_mode  (s_axis_tuser),
    .in_row   (in_row),
    .in_col   (in_col),
    .cmd      (cmd),
    .status   (status)
  );

  // The datapath holds both matrices, the multiply-accumulate pipeline and
  // the output register.
  mrm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .wr_value  (in_value),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_sum   (out_sum),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_sum, out_col, out_row};

endmodule
